[rtl/smpl_pkg.sv]
package smpl_pkg;

    localparam int NUM_MARKS = 7;
    localparam int QBITS     = 6;
    localparam int NUM_W     = 18;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [11:0] SAT_MAX    = 12'hFFF;
    localparam logic [8:0]  BAR_LEFT   = 9'd8;
    localparam logic [8:0]  BAR_RIGHT  = 9'd311;
    localparam logic [8:0]  BAR_ORIGIN = 9'd9;

    typedef logic [NUM_MARKS-1:0][11:0] t_cal;
    typedef logic [NUM_MARKS-1:0][8:0]  t_cols;

    localparam t_cols MARK_COL = {9'd272, 9'd234, 9'd196, 9'd158, 9'd120, 9'd82, 9'd44};
    localparam t_cal  CAL_RESET = {12'd3584, 12'd3072, 12'd2560, 12'd2048,
                                   12'd1536, 12'd1024, 12'd512};

    // One segment lookup: column at the segment start, column rise, offset and span.
    typedef struct packed {
        logic [8:0]       base;
        logic [QBITS-1:0] dcol;
        logic [11:0]      delta;
        logic [11:0]      span;
    } t_seg;

    typedef struct packed {
        t_seg avg;
        t_seg pk;
    } t_pair;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QBITS-1:0] q;
        logic [11:0]      span;
        logic [8:0]       base;
    } t_div;

    function automatic logic [11:0] sat12(input logic [15:0] v);
        logic [11:0] r;
        r = (v > 16'(SAT_MAX)) ? SAT_MAX : v[11:0];
        return r;
    endfunction

    // The first breakpoint at or above the reading picks the segment, so the
    // downward sweep lets lower breakpoints win.
    function automatic t_seg classify(input logic [11:0] raw, input t_cal cal);
        t_seg s;
        s.base  = MARK_COL[NUM_MARKS-1];
        s.dcol  = QBITS'(BAR_RIGHT - MARK_COL[NUM_MARKS-1]);
        s.delta = raw - cal[NUM_MARKS-1];
        s.span  = SAT_MAX - cal[NUM_MARKS-1];
        for (int i = NUM_MARKS - 1; i >= 1; i--) begin
            if (raw <= cal[i]) begin
                s.base  = MARK_COL[i-1];
                s.dcol  = QBITS'(MARK_COL[i] - MARK_COL[i-1]);
                s.delta = raw - cal[i-1];
                s.span  = cal[i] - cal[i-1];
            end
        end
        if (raw <= cal[0]) begin
            s.base  = BAR_LEFT;
            s.dcol  = QBITS'(MARK_COL[0] - BAR_LEFT);
            s.delta = raw;
            s.span  = cal[0];
        end
        // A zero span only comes with a zero offset, which must give no rise.
        if (s.span == 12'd0) begin
            s.span = 12'd1;
        end
        return s;
    endfunction

endpackage

[rtl/smpl_in_if.sv]
interface smpl_in_if;
    import smpl_pkg::*;
    logic        valid;
    logic        ready;
    logic [15:0] average_reading;
    logic [15:0] peak_reading;

    modport source (output valid, output average_reading, output peak_reading, input ready);
    modport sink   (input valid, input average_reading, input peak_reading, output ready);
endinterface

[rtl/smpl_out_if.sv]
interface smpl_out_if;
    import smpl_pkg::*;
    logic       valid;
    logic       ready;
    logic [8:0] bar_width;
    logic [8:0] peak_column;

    modport source (output valid, output bar_width, output peak_column, input ready);
    modport sink   (input valid, input bar_width, input peak_column, output ready);
endinterface

[rtl/smpl_front.sv]
module smpl_front
    import smpl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cal         i_cal,
    smpl_in_if.sink      i_req,
    input  logic         i_full,
    output logic         o_push,
    output t_pair        o_pair
);

    logic  r_valid;
    t_pair r_pair;
    logic  w_take;

    assign o_push      = r_valid && !i_full;
    assign i_req.ready = !r_valid || !i_full;
    assign w_take      = i_req.valid && i_req.ready;
    assign o_pair      = r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pair.avg <= classify(sat12(i_req.average_reading), i_cal);
            r_pair.pk  <= classify(sat12(i_req.peak_reading), i_cal);
        end
    end

endmodule

[rtl/smpl_fifo.sv]
module smpl_fifo
    import smpl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_data,
    output logic  o_full,
    output logic  o_valid,
    output t_pair o_data,
    input  logic  i_pop
);

    t_pair             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/smpl_back.sv]
module smpl_back
    import smpl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_pair       i_pair,
    output logic        o_pop,
    smpl_out_if.source  o_res
);

    // Stage 0 holds the product, stages 1..QBITS each settle one quotient bit.
    t_div       r_st [2][QBITS+1];
    t_div       n_st [2][QBITS+1];
    logic [QBITS:0] r_v;
    logic       r_out_valid;
    logic [8:0] r_bar;
    logic [8:0] r_peak;
    logic       w_en;
    logic [8:0] w_col [2];
    t_seg       w_seg [2];

    assign w_en  = !r_out_valid || o_res.ready;
    assign o_pop = w_en && i_valid;

    assign w_seg[0] = i_pair.avg;
    assign w_seg[1] = i_pair.pk;

    always_comb begin
        logic [NUM_W-1:0] trial;
        logic [8:0]       col;
        for (int l = 0; l < 2; l++) begin
            n_st[l][0].rem  = NUM_W'({12'd0, w_seg[l].dcol} * {6'd0, w_seg[l].delta});
            n_st[l][0].q    = '0;
            n_st[l][0].span = w_seg[l].span;
            n_st[l][0].base = w_seg[l].base;
            for (int s = 1; s <= QBITS; s++) begin
                n_st[l][s] = r_st[l][s-1];
                trial = NUM_W'(r_st[l][s-1].span) << (QBITS - s);
                if (r_st[l][s-1].rem >= trial) begin
                    n_st[l][s].rem          = r_st[l][s-1].rem - trial;
                    n_st[l][s].q[QBITS - s] = 1'b1;
                end
            end
            col = r_st[l][QBITS].base + 9'(r_st[l][QBITS].q);
            w_col[l] = (col > BAR_RIGHT) ? BAR_RIGHT : col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v         <= {r_v[QBITS-1:0], i_valid};
            r_out_valid <= r_v[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                for (int s = 0; s <= QBITS; s++) begin
                    r_st[l][s] <= n_st[l][s];
                end
            end
            r_bar  <= (w_col[0] > BAR_ORIGIN) ? (w_col[0] - BAR_ORIGIN) : 9'd0;
            r_peak <= w_col[1];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.bar_width   = r_bar;
    assign o_res.peak_column = r_peak;

endmodule

[rtl/smeter_piecewise_linear_map.sv]
// Signal meter column mapper.
// Requests arrive on i_req (valid/ready) carrying an average and a peak reading;
// each reading saturates at 4095 and maps through seven breakpoints onto the
// meter's pixel columns. Results leave on o_res as the bar width and the peak
// marker column, one result per request, in request order.
// The breakpoints are written over the APB port at byte addresses 0, 4, ... 24;
// the user must write them only while no request is in flight, as the block
// does not enforce this; pready is always high. Throughput is one request per
// cycle while o_res.ready stays high. From acceptance, a result passes a
// classify register, a four-entry queue, a multiply register, six one-bit
// divider stages and the output register on its way to o_res.valid.
// When the receiver stalls, the back pipeline holds its contents, the queue
// fills, and i_req.ready drops once the queue and the classify register are
// full. Reset empties the pipeline and the queue and restores the default
// breakpoints 512, 1024 ... 3584.
module smeter_piecewise_linear_map
    import smpl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    smpl_in_if.sink      i_req,
    smpl_out_if.source   o_res
);

    t_cal       r_cal;
    logic [2:0] w_idx;
    logic       w_full;
    logic       w_push;
    t_pair      w_front_pair;
    logic       w_q_valid;
    t_pair      w_q_pair;
    logic       w_pop;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign prdata = (int'(w_idx) < NUM_MARKS) ? {20'd0, r_cal[w_idx]} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= CAL_RESET;
        end else if (psel && penable && pwrite && pready && int'(w_idx) < NUM_MARKS) begin
            r_cal[w_idx] <= pwdata[11:0];
        end
    end

    smpl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_pair  (w_front_pair)
    );

    smpl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_pair),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_pair),
        .i_pop   (w_pop)
    );

    smpl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_pair  (w_q_pair),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

[rtl/smpl_checker.sv]
module smpl_checker
    import smpl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [8:0] i_bar_width,
    input logic [8:0] i_peak_column
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bar_width)
            && $stable(i_peak_column))
        else $error("stalled result changed");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_peak_column >= BAR_LEFT && i_peak_column <= BAR_RIGHT)
        else $error("peak column out of range");

    a_bar_vs_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bar_width <= (BAR_RIGHT - BAR_ORIGIN))
        else $error("bar width out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind smeter_piecewise_linear_map smpl_checker u_smpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pready      (pready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_bar_width   (o_res.bar_width),
    .i_peak_column (o_res.peak_column)
);

[tb/sv/smeter_map_checker.sv]
module smeter_map_checker
    import smpl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    smpl_in_if          mon_req,
    smpl_out_if         mon_res,
    output int          o_pending,
    output int          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEFT_COL    = 8;
    localparam int unsigned RIGHT_COL   = 311;
    localparam int unsigned FIRST_BAR   = 9;
    localparam int unsigned READING_MAX = 4095;
    localparam int unsigned SEG_COL [7] = '{44, 82, 120, 158, 196, 234, 272};
    localparam int unsigned BP_RESET [7] = '{512, 1024, 1536, 2048, 2560, 3072, 3584};

    typedef struct {
        logic [8:0] bar_width;
        logic [8:0] peak_column;
    } meter_reading_t;

    int unsigned    breakpoints [7];
    meter_reading_t expected_meter [$];

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
    end

    // Column for one reading: the first breakpoint at or above the saturated
    // reading picks the segment, which starts at the breakpoint passed last.
    function automatic int unsigned meter_column(input logic [15:0] reading);
        int unsigned raw;
        int unsigned span;
        int unsigned x;
        raw = (reading > 16'(READING_MAX)) ? READING_MAX : int'(reading);
        if (raw <= breakpoints[0]) begin
            if (breakpoints[0] == 0) begin
                return LEFT_COL;
            end
            return LEFT_COL + ((SEG_COL[0] - LEFT_COL) * raw) / breakpoints[0];
        end
        for (int i = 1; i < 7; i++) begin
            if (raw <= breakpoints[i]) begin
                span = breakpoints[i] - breakpoints[i-1];
                return SEG_COL[i-1]
                       + ((SEG_COL[i] - SEG_COL[i-1]) * (raw - breakpoints[i-1])) / span;
            end
        end
        span = READING_MAX - breakpoints[6];
        if (span == 0) begin
            return SEG_COL[6];
        end
        x = SEG_COL[6] + ((RIGHT_COL - SEG_COL[6]) * (raw - breakpoints[6])) / span;
        return (x > RIGHT_COL) ? RIGHT_COL : x;
    endfunction

    function automatic meter_reading_t predict_meter(input logic [15:0] average,
                                                     input logic [15:0] peak);
        meter_reading_t m;
        int unsigned avg_col;
        avg_col = meter_column(average);
        m.bar_width   = 9'((avg_col > FIRST_BAR) ? avg_col - FIRST_BAR : 0);
        m.peak_column = 9'(meter_column(peak));
        return m;
    endfunction

    task automatic report_mismatch(input string what);
        o_mismatches++;
        $display("%0t ns: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        meter_reading_t want;
        if (!i_rst_n) begin
            breakpoints = BP_RESET;
            expected_meter.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && int'(i_paddr[4:2]) < NUM_MARKS) begin
                breakpoints[i_paddr[4:2]] = int'(i_pwdata[11:0]);
            end
            if (mon_req.valid && mon_req.ready) begin
                expected_meter.push_back(predict_meter(mon_req.average_reading,
                                                       mon_req.peak_reading));
            end
            if (mon_res.valid && mon_res.ready) begin
                if (expected_meter.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_meter.pop_front();
                    if (mon_res.bar_width !== want.bar_width) begin
                        report_mismatch($sformatf("bar_width %0d, expected %0d",
                                                  mon_res.bar_width, want.bar_width));
                    end
                    if (mon_res.peak_column !== want.peak_column) begin
                        report_mismatch($sformatf("peak_column %0d, expected %0d",
                                                  mon_res.peak_column, want.peak_column));
                    end
                end
            end
        end
        o_pending <= expected_meter.size();
    end

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_CAL_RAW_1 = 0;
    localparam int REG_CAL_RAW_7 = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int BLOCKS        = 10;
    localparam int RANDOM_PER_BLOCK = 75;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_requests;
    int          pending;
    int          mismatches;
    logic [11:0] cal_now [7];

    smpl_in_if  req_if ();
    smpl_out_if res_if ();

    smeter_piecewise_linear_map uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    smeter_map_checker meter_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .mon_req      (req_if),
        .mon_res      (res_if),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("smeter_piecewise_linear_map test failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request so the
    // queue fills and the request channel backs up.
    initial begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (holds_done != hold_requests) begin
                res_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_reading(input logic [15:0] average, input logic [15:0] peak);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.average_reading <= average;
        req_if.peak_reading    <= peak;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_breakpoint(input int idx, input logic [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        cal_now[idx] = value;
    endtask

    // Mostly in-range readings, a share within two of the breakpoints, and some
    // full-width values that exercise saturation and every input bit.
    function automatic logic [15:0] random_reading();
        int pick;
        int near;
        pick = $urandom_range(99);
        if (pick < 15) begin
            return 16'($urandom_range(65535));
        end else if (pick < 35) begin
            near = int'(cal_now[$urandom_range(6)]) + int'($urandom_range(4)) - 2;
            if (near < 0) begin
                near = 0;
            end
            return 16'(near);
        end
        return 16'($urandom_range(4095));
    endfunction

    initial begin
        logic [11:0]  pts [7];
        int unsigned  sorted_pts [$];
        logic [15:0]  first_pairs [22][2];

        first_pairs = '{'{0, 0}, '{4095, 4095}, '{4096, 65535}, '{65535, 0},
                        '{1, 1}, '{28, 29}, '{29, 15}, '{512, 513}, '{1024, 1025},
                        '{1536, 1537}, '{2048, 2049}, '{2560, 2561}, '{3072, 3073},
                        '{3584, 3585}, '{4094, 3583}, '{511, 1023}, '{16'hAAAA, 16'h5555},
                        '{16'h5555, 16'hAAAA}, '{2000, 100}, '{100, 2000}, '{3800, 3900},
                        '{16'h0FFF, 16'h1000}};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 0;
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_if.valid           <= 1'b0;
        req_if.average_reading <= '0;
        req_if.peak_reading    <= '0;
        cal_now = '{512, 1024, 1536, 2048, 2560, 3072, 3584};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int blk = 0; blk < BLOCKS; blk++) begin
            if (blk < 4) begin
                send_idle_pct = 21;
                recv_idle_pct = 45;
            end else if (blk < 7) begin
                send_idle_pct = 45;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (blk != 0) begin
                pts = cal_now;
                sorted_pts.delete();
                for (int i = 0; i < 7; i++) begin
                    sorted_pts.push_back($urandom_range(4095, 1));
                end
                sorted_pts.sort();
                case (blk)
                    1: pts = '{1, 2, 3, 4, 5, 6, 7};
                    // A zero first breakpoint leaves only a reading of zero in
                    // the first segment.
                    2: pts = '{0, 600, 1200, 1800, 2400, 3000, 3600};
                    3: pts = '{4095, 4095, 4095, 4095, 4095, 4095, 4095};
                    // Unordered breakpoints.
                    4: for (int i = 0; i < 7; i++) pts[i] = 12'($urandom_range(4095, 1));
                    // Last breakpoint at full scale, so the tail cannot be reached.
                    5: begin
                        for (int i = 0; i < 7; i++) pts[i] = 12'(sorted_pts[i]);
                        pts[6] = 12'd4095;
                    end
                    6: pts = '{1, 1, 1, 1, 1, 1, 1};
                    7: for (int i = 0; i < 7; i++) pts[i] = 12'(sorted_pts[i]);
                    8: for (int i = 0; i < 7; i++) pts[i] = 12'($urandom_range(4095));
                    default: pts = '{512, 1024, 1536, 2048, 2560, 3072, 3584};
                endcase
                wait_drained();
                for (int i = REG_CAL_RAW_1; i <= REG_CAL_RAW_7; i++) begin
                    write_breakpoint(i, pts[i]);
                end
            end

            if (blk == 7) begin
                hold_requests++;
            end

            if (blk == 0) begin
                foreach (first_pairs[i]) begin
                    send_reading(first_pairs[i][0], first_pairs[i][1]);
                end
            end else begin
                for (int i = 0; i < 7; i++) begin
                    send_reading(16'(cal_now[i]), 16'(cal_now[i]) + 16'd1);
                end
                send_reading(16'd0, 16'd4095);
                send_reading(16'hFFFF, 16'd1);
            end

            for (int i = 0; i < RANDOM_PER_BLOCK; i++) begin
                send_reading(random_reading(), random_reading());
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("smeter_piecewise_linear_map test passed");
        end else begin
            $display("smeter_piecewise_linear_map test failed");
        end
        $finish;
    end

endmodule

[smeter_piecewise_linear_map.f]
rtl/smpl_pkg.sv
rtl/smpl_in_if.sv
rtl/smpl_out_if.sv
rtl/smpl_front.sv
rtl/smpl_fifo.sv
rtl/smpl_back.sv
rtl/smeter_piecewise_linear_map.sv
rtl/smpl_checker.sv
tb/sv/smeter_map_checker.sv
tb/sv/testbench.sv
